FILE: hw/rtl/paged_block_allocator_defines.svh
// ----------------------------------------------------------------------------
// paged block allocator assertion macros
// concurrent checks that vanish when synthesis is defined
// ----------------------------------------------------------------------------
`ifndef PAGED_BLOCK_ALLOCATOR_DEFINES_SVH
`define PAGED_BLOCK_ALLOCATOR_DEFINES_SVH

`ifndef SYNTHESIS
// property must hold at every clock edge out of reset
`define PBA_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("pba assertion failed");
// expression must never be true out of reset
`define PBA_ASSERT_NEVER(label, clk, rst_n, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("pba forbidden condition seen");
`else
`define PBA_ASSERT(label, clk, rst_n, prop)
`define PBA_ASSERT_NEVER(label, clk, rst_n, expr)
`endif

`endif

FILE: hw/rtl/pba_pkg.sv
// ----------------------------------------------------------------------------
// pba_pkg
// shared constants and types of the paged block allocator
// ----------------------------------------------------------------------------
`default_nettype none

package pba_pkg;

  // default sizes
  localparam int NUM_BLOCKS_DEF  = 128;
  localparam int OWNER_SLOTS_DEF = 16;
  localparam int MAX_PAGES_DEF   = 32;

  // request codes
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // result status codes
  typedef enum logic [2:0] {
    STATUS_OK       = 3'd0,
    STATUS_DUP      = 3'd1,
    STATUS_NOSPACE  = 3'd2,
    STATUS_FULL     = 3'd3,
    STATUS_NOTFOUND = 3'd4,
    STATUS_BADCOUNT = 3'd5
  } status_e;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_ALLOC,
    S_FREE,
    S_RESP
  } state_e;

endpackage

`default_nettype wire

FILE: hw/rtl/pba_req_if.sv
// ----------------------------------------------------------------------------
// pba_req_if
// request channel: allocate or free for one owner
// ----------------------------------------------------------------------------
`default_nettype none

interface pba_req_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [6:0] owner_id;
  logic [5:0] page_count;

  modport source (output valid, output op, output owner_id, output page_count,
                  input ready);
  modport sink   (input valid, input op, input owner_id, input page_count,
                  output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/pba_rsp_if.sv
// ----------------------------------------------------------------------------
// pba_rsp_if
// result channel: one transfer per granted block or per status
// ----------------------------------------------------------------------------
`default_nettype none

interface pba_rsp_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic       block_valid;
  logic [6:0] block_index;
  logic       last;
  logic [7:0] free_blocks;

  modport source (output valid, output status, output block_valid,
                  output block_index, output last, output free_blocks,
                  input ready);
  modport sink   (input valid, input status, input block_valid,
                  input block_index, input last, input free_blocks,
                  output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/paged_block_allocator.sv
// ----------------------------------------------------------------------------
// paged_block_allocator
// first-fit block allocator over a busy bitmap with an owner table
// ----------------------------------------------------------------------------
// channel   dir   modport  payload
// req_i     in    sink     op, owner_id, page_count
// rsp_o     out   source   status, block_valid, block_index, last, free_blocks
//
// every request walks the owner table one slot a cycle, then passes a decision
// state; allocate then walks the bitmap one block a cycle but waits on a vacant
// block while the result register is stalled, free reads the block list from
// the list memory one entry a cycle and ends with a status state.
// reset clears the bitmap, the slot valid bits and the in-use count at once.
// a stalled result register holds the allocate walk and the status state;
// req_i is ready only in idle.
`default_nettype none

`include "paged_block_allocator_defines.svh"

module paged_block_allocator #(
  parameter int NUM_BLOCKS  = pba_pkg::NUM_BLOCKS_DEF,
  parameter int OWNER_SLOTS = pba_pkg::OWNER_SLOTS_DEF,
  parameter int MAX_PAGES   = pba_pkg::MAX_PAGES_DEF
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  pba_req_if.sink   req_i,
  pba_rsp_if.source rsp_o
);

  import pba_pkg::*;

  localparam int BW    = $clog2(NUM_BLOCKS);
  localparam int UW    = $clog2(NUM_BLOCKS + 1);
  localparam int SW    = (OWNER_SLOTS > 1) ? $clog2(OWNER_SLOTS) : 1;
  localparam int PW    = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
  localparam int PCW   = $clog2(MAX_PAGES + 1);
  localparam int DEPTH = OWNER_SLOTS * MAX_PAGES;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // list memory address of one page of one slot
  function automatic logic [AW-1:0] list_addr(logic [SW-1:0] s, logic [PW-1:0] p);
    list_addr = AW'(AW'(s) * AW'(MAX_PAGES)) + AW'(p);
  endfunction

  // sequencer and request registers
  state_e            state_q, state_d;
  logic              op_q;
  logic [6:0]        id_q;
  logic [5:0]        cnt_q;
  logic [SW-1:0]     slot_idx_q;
  logic              match_q;
  logic [SW-1:0]     match_slot_q;
  logic              have_free_q;
  logic [SW-1:0]     free_slot_q;
  logic [BW-1:0]     blk_q;
  logic [PCW-1:0]    n_q;
  logic [PCW-1:0]    page_q;
  logic [PCW-1:0]    pages_q;
  logic              rd_pend_q;
  status_e           resp_status_q;

  // allocator state
  logic [NUM_BLOCKS-1:0]  busy_q;
  logic [OWNER_SLOTS-1:0] slot_valid_q;
  logic [6:0]             slot_owner_q [OWNER_SLOTS];
  logic [PCW-1:0]         slot_pages_q [OWNER_SLOTS];
  logic [UW-1:0]          in_use_q;
  logic [BW-1:0]          list_mem [DEPTH];
  logic [BW-1:0]          rd_data_q;

  // result register
  logic              out_valid_q;
  status_e           out_status_q;
  logic              out_bvalid_q;
  logic [6:0]        out_index_q;
  logic              out_last_q;
  logic [7:0]        out_free_q;

  // control
  logic              req_xfer;
  logic              scan_last;
  logic              can_load;
  logic              blk_vacant;
  logic              alloc_take;
  logic              alloc_step;
  logic              alloc_done;
  logic              rd_issue;
  logic              free_end;
  logic              dec_err;
  status_e           dec_status;
  logic [UW-1:0]     vacant;
  logic [UW+7:0]     vacant_ext;
  logic [BW+6:0]     blk_ext;
  logic              bad_count;
  logic              no_space;

  // vacant count and narrowed views
  assign vacant     = UW'(NUM_BLOCKS) - in_use_q;
  assign vacant_ext = {8'd0, vacant};
  assign blk_ext    = {7'd0, blk_q};

  // allocate checks in priority order
  assign bad_count = (cnt_q == 6'd0) || ({1'b0, cnt_q} > 7'(MAX_PAGES));
  assign no_space  = ({2'b00, cnt_q} > vacant_ext[7:0]) ||
                     ({6'd0, vacant} < {{UW{1'b0}}, cnt_q});

  always_comb begin
    dec_err    = 1'b1;
    dec_status = STATUS_OK;
    if (op_q == OP_FREE) begin
      dec_err    = !match_q;
      dec_status = match_q ? STATUS_OK : STATUS_NOTFOUND;
    end else if (match_q) begin
      dec_status = STATUS_DUP;
    end else if (bad_count) begin
      dec_status = STATUS_BADCOUNT;
    end else if (no_space) begin
      dec_status = STATUS_NOSPACE;
    end else if (!have_free_q) begin
      dec_status = STATUS_FULL;
    end else begin
      dec_err = 1'b0;
    end
  end

  // handshake and step conditions
  always_comb begin
    req_xfer   = req_i.valid && (state_q == S_IDLE);
    scan_last  = (slot_idx_q == SW'(OWNER_SLOTS - 1));
    can_load   = !out_valid_q || rsp_o.ready;
    blk_vacant = !busy_q[blk_q];
    alloc_take = (state_q == S_ALLOC) && blk_vacant && can_load;
    alloc_step = (state_q == S_ALLOC) && (!blk_vacant || can_load);
    alloc_done = alloc_take && (n_q == pages_q - PCW'(1));
    rd_issue   = (state_q == S_FREE) && (page_q != pages_q);
    free_end   = (state_q == S_FREE) && (page_q == pages_q) && !rd_pend_q;
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:   if (req_i.valid) state_d = S_SCAN;
      S_SCAN:   if (scan_last) state_d = S_DECIDE;
      S_DECIDE: begin
        if (dec_err) begin
          state_d = S_RESP;
        end else if (op_q == OP_FREE) begin
          state_d = S_FREE;
        end else begin
          state_d = S_ALLOC;
        end
      end
      S_ALLOC:  if (alloc_done) state_d = S_IDLE;
      S_FREE:   if (free_end) state_d = S_RESP;
      S_RESP:   if (can_load) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  // port outputs
  always_comb begin
    req_i.ready       = (state_q == S_IDLE);
    rsp_o.valid       = out_valid_q;
    rsp_o.status      = out_status_q;
    rsp_o.block_valid = out_bvalid_q;
    rsp_o.block_index = out_index_q;
    rsp_o.last        = out_last_q;
    rsp_o.free_blocks = out_free_q;
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      busy_q       <= '0;
      slot_valid_q <= '0;
      in_use_q     <= '0;
      out_valid_q  <= 1'b0;
      rd_pend_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      rd_pend_q <= rd_issue;

      // result register load and drain
      if (alloc_take || ((state_q == S_RESP) && can_load)) out_valid_q <= 1'b1;
      else if (rsp_o.ready) out_valid_q <= 1'b0;

      // bitmap updates
      if (alloc_take) busy_q[blk_q] <= 1'b1;
      if (rd_pend_q) busy_q[rd_data_q] <= 1'b0;

      // table commit at decision
      if ((state_q == S_DECIDE) && !dec_err) begin
        if (op_q == OP_FREE) begin
          slot_valid_q[match_slot_q] <= 1'b0;
          in_use_q <= (in_use_q >= UW'(slot_pages_q[match_slot_q])) ?
                      in_use_q - UW'(slot_pages_q[match_slot_q]) : '0;
        end else begin
          slot_valid_q[free_slot_q] <= 1'b1;
          in_use_q <= in_use_q + UW'(cnt_q);
        end
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    // request capture
    if (req_xfer) begin
      op_q        <= req_i.op;
      id_q        <= req_i.owner_id;
      cnt_q       <= req_i.page_count;
      slot_idx_q  <= '0;
      match_q     <= 1'b0;
      have_free_q <= 1'b0;
    end

    // owner table walk, one slot a cycle through the shared compare
    if (state_q == S_SCAN) begin
      slot_idx_q <= slot_idx_q + SW'(1);
      if (slot_valid_q[slot_idx_q] && (slot_owner_q[slot_idx_q] == id_q)) begin
        match_q      <= 1'b1;
        match_slot_q <= slot_idx_q;
      end
      if (!slot_valid_q[slot_idx_q] && !have_free_q) begin
        have_free_q <= 1'b1;
        free_slot_q <= slot_idx_q;
      end
    end

    // decision: set up walk counters and the new table entry
    if (state_q == S_DECIDE) begin
      resp_status_q <= dec_status;
      blk_q         <= '0;
      n_q           <= '0;
      page_q        <= '0;
      if (op_q == OP_FREE) begin
        pages_q <= slot_pages_q[match_slot_q];
      end else begin
        pages_q <= PCW'(cnt_q);
        if (!dec_err) begin
          slot_owner_q[free_slot_q] <= id_q;
          slot_pages_q[free_slot_q] <= PCW'(cnt_q);
        end
      end
    end

    // bitmap walk for allocate
    if (alloc_step) blk_q <= blk_q + BW'(1);
    if (alloc_take) n_q <= n_q + PCW'(1);

    // block list walk for free
    if (rd_issue) page_q <= page_q + PCW'(1);

    // result payload
    if (alloc_take) begin
      out_status_q <= STATUS_OK;
      out_bvalid_q <= 1'b1;
      out_index_q  <= blk_ext[6:0];
      out_last_q   <= (n_q == pages_q - PCW'(1));
      out_free_q   <= vacant_ext[7:0];
    end else if ((state_q == S_RESP) && can_load) begin
      out_status_q <= resp_status_q;
      out_bvalid_q <= 1'b0;
      out_index_q  <= 7'd0;
      out_last_q   <= 1'b1;
      out_free_q   <= vacant_ext[7:0];
    end
  end

  // block list memory
  always_ff @(posedge clk_i) begin
    if (alloc_take) list_mem[list_addr(free_slot_q, n_q[PW-1:0])] <= blk_q;
    if (rd_issue) rd_data_q <= list_mem[list_addr(match_slot_q, page_q[PW-1:0])];
  end

  // checks
  `PBA_ASSERT_NEVER(a_in_use_bound, clk_i, rst_ni, in_use_q > UW'(NUM_BLOCKS))
  `PBA_ASSERT(a_grant_marks_busy, clk_i, rst_ni, alloc_take |=> busy_q[$past(blk_q)])
  `PBA_ASSERT(a_req_starts_scan, clk_i, rst_ni, req_xfer |=> state_q == S_SCAN)

endmodule

`default_nettype wire

FILE: tb/sv/tb_paged_block_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_paged_block_allocator
// drives allocate and free requests into the paged block allocator, keeps a
// shadow bitmap and owner table to predict every block grant and status, and
// compares each result transfer against the oldest prediction, under
// several source and sink idling mixes
// ----------------------------------------------------------------------------

module tb_paged_block_allocator;
  import pba_pkg::*;

  localparam int NUM_BLOCKS     = NUM_BLOCKS_DEF;
  localparam int OWNER_SLOTS    = OWNER_SLOTS_DEF;
  localparam int MAX_PAGES      = MAX_PAGES_DEF;
  localparam int RANDOM_ITEMS   = 350;
  localparam int HOLD_OFF       = 400;
  localparam int DRAIN_CYCLES   = 300;
  localparam int WATCHDOG_LIMIT = 4000;

  // one result transfer as seen on the output channel
  typedef struct {
    logic [2:0] status;
    logic       block_valid;
    logic [6:0] block_index;
    logic       last;
    logic [7:0] free_blocks;
  } grant_t;

  // shadow of the allocator state plus the queue of predicted grants
  class alloc_ledger;
    bit         busy [NUM_BLOCKS];
    bit         slot_used [OWNER_SLOTS];
    bit [6:0]   slot_owner [OWNER_SLOTS];
    int         slot_pages [OWNER_SLOTS];
    bit [6:0]   slot_blocks [OWNER_SLOTS][MAX_PAGES];
    int         in_use;
    grant_t     pending_grants [$];
    int         mismatches;

    function new();
      foreach (busy[b]) busy[b] = 1'b0;
      foreach (slot_used[s]) slot_used[s] = 1'b0;
      in_use     = 0;
      mismatches = 0;
    endfunction

    function int find_owner(logic [6:0] id);
      for (int s = 0; s < OWNER_SLOTS; s++)
        if (slot_used[s] && slot_owner[s] == id) return s;
      return -1;
    endfunction

    function int live_owners();
      int n;
      n = 0;
      foreach (slot_used[s]) if (slot_used[s]) n++;
      return n;
    endfunction

    // owner id of a randomly chosen occupied slot
    function logic [6:0] any_live_owner();
      int pick;
      pick = $urandom_range(0, live_owners() - 1);
      for (int s = 0; s < OWNER_SLOTS; s++)
        if (slot_used[s]) begin
          if (pick == 0) return slot_owner[s];
          pick--;
        end
      return 7'd0;
    endfunction

    function void push_grant(logic [2:0] st, logic bv, logic [6:0] idx, logic lst);
      grant_t g;
      g.status      = st;
      g.block_valid = bv;
      g.block_index = idx;
      g.last        = lst;
      g.free_blocks = 8'(NUM_BLOCKS - in_use);
      pending_grants.push_back(g);
    endfunction

    // predict the grants of one accepted request and update the shadow state
    function void note_request(logic op, logic [6:0] id, logic [5:0] cnt);
      int slot;
      int taken;
      slot = find_owner(id);
      if (op == OP_FREE) begin
        if (slot < 0) begin
          push_grant(STATUS_NOTFOUND, 1'b0, 7'd0, 1'b1);
        end else begin
          for (int p = 0; p < slot_pages[slot]; p++) busy[slot_blocks[slot][p]] = 1'b0;
          in_use -= slot_pages[slot];
          slot_used[slot] = 1'b0;
          push_grant(STATUS_OK, 1'b0, 7'd0, 1'b1);
        end
      end else if (slot >= 0) begin
        push_grant(STATUS_DUP, 1'b0, 7'd0, 1'b1);
      end else if (cnt == 0 || cnt > MAX_PAGES) begin
        push_grant(STATUS_BADCOUNT, 1'b0, 7'd0, 1'b1);
      end else if (NUM_BLOCKS - in_use < cnt) begin
        push_grant(STATUS_NOSPACE, 1'b0, 7'd0, 1'b1);
      end else begin
        // lowest free slot, then first-fit over the bitmap
        for (int s = OWNER_SLOTS - 1; s >= 0; s--) if (!slot_used[s]) slot = s;
        if (slot < 0) begin
          push_grant(STATUS_FULL, 1'b0, 7'd0, 1'b1);
        end else begin
          taken = 0;
          for (int b = 0; b < NUM_BLOCKS && taken < cnt; b++)
            if (!busy[b]) begin
              busy[b] = 1'b1;
              slot_blocks[slot][taken] = 7'(b);
              taken++;
            end
          slot_used[slot]  = 1'b1;
          slot_owner[slot] = id;
          slot_pages[slot] = taken;
          in_use += taken;
          for (int p = 0; p < taken; p++)
            push_grant(STATUS_OK, 1'b1, slot_blocks[slot][p], 1'(p == taken - 1));
        end
      end
    endfunction

    function void compare_field(string name, int want, int seen);
      if (want != seen) begin
        $display("%0t mismatch on %s: expected %0d, actual %0d", $time, name, want, seen);
        mismatches++;
      end
    endfunction

    // compare one result transfer with the oldest prediction
    function void check_result(grant_t got);
      grant_t want;
      if (pending_grants.size() == 0) begin
        $display("%0t unexpected result: expected none, actual status %0d index %0d",
                 $time, got.status, got.block_index);
        mismatches++;
      end else begin
        want = pending_grants.pop_front();
        compare_field("status", want.status, got.status);
        compare_field("block_valid", want.block_valid, got.block_valid);
        compare_field("block_index", want.block_index, got.block_index);
        compare_field("last", want.last, got.last);
        compare_field("free_blocks", want.free_blocks, got.free_blocks);
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;

  pba_req_if req_if ();
  pba_rsp_if rsp_if ();

  alloc_ledger ledger;
  int          source_idle_pct;
  int          sink_stall_pct;
  bit          long_hold_go;
  bit          long_hold_done;
  int          hold_left;
  int          quiet_cycles;

  paged_block_allocator DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if.sink),
    .rsp_o  (rsp_if.source)
  );

  // clock
  always #6 clk_i = ~clk_i;

  // observe transfers on both channels at the rising edge
  always @(posedge clk_i) begin
    grant_t got;
    if (!rst_ni) begin
      quiet_cycles = 0;
    end else begin
      if (req_if.valid && req_if.ready)
        ledger.note_request(req_if.op, req_if.owner_id, req_if.page_count);
      if (rsp_if.valid && rsp_if.ready) begin
        got.status      = rsp_if.status;
        got.block_valid = rsp_if.block_valid;
        got.block_index = rsp_if.block_index;
        got.last        = rsp_if.last;
        got.free_blocks = rsp_if.free_blocks;
        ledger.check_result(got);
      end
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
  end

  // watchdog on cycles without any transfer
  initial begin
    wait (quiet_cycles >= WATCHDOG_LIMIT);
    $display("tb_paged_block_allocator NOT OK");
    $finish;
  end

  // result sink: random stalls plus one long hold-off on request
  initial begin
    rsp_if.ready   = 1'b0;
    hold_left      = 0;
    long_hold_done = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (long_hold_go && !long_hold_done) begin
        hold_left      = HOLD_OFF;
        long_hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= ($urandom_range(0, 99) >= sink_stall_pct);
      end
    end
  end

  // offer one request and wait for its transfer, leaving at a falling edge
  task automatic send_request(input logic op, input logic [6:0] id, input logic [5:0] cnt);
    while ($urandom_range(0, 99) < source_idle_pct) begin
      req_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    req_if.valid      <= 1'b1;
    req_if.op         <= op;
    req_if.owner_id   <= id;
    req_if.page_count <= cnt;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // mostly well-formed allocate and free traffic, some errors and noise
  task automatic random_request(output logic op, output logic [6:0] id,
                                output logic [5:0] cnt);
    int roll;
    int size_roll;
    roll      = $urandom_range(0, 99);
    size_roll = $urandom_range(0, 99);
    op        = OP_ALLOC;
    id        = 7'($urandom_range(0, 127));
    if (size_roll < 70) cnt = 6'($urandom_range(1, 8));
    else if (size_roll < 95) cnt = 6'($urandom_range(9, 31));
    else cnt = 6'(MAX_PAGES);
    if (roll < 45) begin
      while (ledger.find_owner(id) >= 0) id = 7'($urandom_range(0, 127));
    end else if (roll < 80) begin
      op  = OP_FREE;
      cnt = 6'($urandom_range(0, 63));
      if (ledger.live_owners() > 0) id = ledger.any_live_owner();
    end else if (roll < 86) begin
      if (ledger.live_owners() > 0) id = ledger.any_live_owner();
    end else if (roll < 92) begin
      cnt = ($urandom_range(0, 3) == 0) ? 6'd0 : 6'($urandom_range(MAX_PAGES + 1, 63));
    end else begin
      op  = 1'($urandom_range(0, 1));
      cnt = 6'($urandom_range(0, 63));
    end
  endtask

  // main sequence
  initial begin
    logic       op;
    logic [6:0] id;
    logic [5:0] cnt;
    int         idle_mix [4][2];

    ledger            = new();
    rst_ni            = 1'b0;
    req_if.valid      = 1'b0;
    req_if.op         = OP_ALLOC;
    req_if.owner_id   = 7'd0;
    req_if.page_count = 6'd0;
    source_idle_pct   = 0;
    sink_stall_pct    = 0;
    long_hold_go      = 1'b0;
    idle_mix          = '{'{0, 0}, '{58, 0}, '{0, 58}, '{34, 34}};

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: error ordering, nearly full bitmap, slot reuse, full table
    send_request(OP_FREE, 7'd0, 6'd0);
    send_request(OP_ALLOC, 7'd0, 6'd0);
    send_request(OP_ALLOC, 7'd127, 6'd63);
    send_request(OP_ALLOC, 7'd0, 6'd32);
    send_request(OP_ALLOC, 7'd0, 6'd0);
    send_request(OP_ALLOC, 7'd127, 6'd32);
    send_request(OP_ALLOC, 7'd1, 6'd32);
    send_request(OP_ALLOC, 7'd2, 6'd31);
    send_request(OP_ALLOC, 7'd3, 6'd2);
    send_request(OP_ALLOC, 7'd3, 6'd33);
    send_request(OP_FREE, 7'd127, 6'd63);
    send_request(OP_ALLOC, 7'd4, 6'd1);
    for (int i = 0; i < OWNER_SLOTS - 4; i++) send_request(OP_ALLOC, 7'(20 + i), 6'd1);
    send_request(OP_ALLOC, 7'd40, 6'd32);
    send_request(OP_ALLOC, 7'd41, 6'd1);

    // random phases, each starting from a drained block
    for (int ph = 0; ph < 4; ph++) begin
      req_if.valid <= 1'b0;
      while (ledger.pending_grants.size() != 0) @(negedge clk_i);
      @(negedge clk_i);
      source_idle_pct = idle_mix[ph][0];
      sink_stall_pct  = idle_mix[ph][1];
      if (ph == 0) long_hold_go = 1'b1;
      for (int n = 0; n < RANDOM_ITEMS / 4; n++) begin
        random_request(op, id, cnt);
        send_request(op, id, cnt);
      end
    end
    req_if.valid <= 1'b0;

    // drain, then watch for stray results
    while (ledger.pending_grants.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (ledger.mismatches == 0 && ledger.pending_grants.size() == 0)
      $display("tb_paged_block_allocator OK");
    else
      $display("tb_paged_block_allocator NOT OK");
    $finish;
  end

endmodule

FILE: paged_block_allocator.f
+incdir+hw/rtl
hw/rtl/pba_pkg.sv
hw/rtl/pba_req_if.sv
hw/rtl/pba_rsp_if.sv
hw/rtl/paged_block_allocator.sv
tb/sv/tb_paged_block_allocator.sv
